// File: rtl/stream_find_and_replace_core_defines.svh
// Assertion macros for the stream find-and-replace core.
// No dependencies; the including module must provide clk and rst_n.
`ifndef STREAM_FIND_AND_REPLACE_CORE_DEFINES_SVH
`define STREAM_FIND_AND_REPLACE_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a condition at every clock edge outside reset
`define SFR_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("stream_find_and_replace_core: check failed");
// Check that a trigger is followed by a condition in the next cycle
`define SFR_ASSERT_STEP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("stream_find_and_replace_core: check failed");
`else
`define SFR_ASSERT(label, prop)
`define SFR_ASSERT_STEP(label, ante, cons)
`endif
`endif

// File: rtl/sfr_pkg.sv
// Shared types, constants and helper functions of the stream find-and-replace core.
// No dependencies; every RTL file of the block refers to it by scoped names.
package sfr_pkg;

  localparam int MAX_PATTERN = 8;
  localparam int BYTE_W      = 8;
  localparam int PACK_W      = MAX_PATTERN * BYTE_W;
  localparam int LEN_W       = 4;
  localparam int WIN_IDX_W   = $clog2(MAX_PATTERN);
  localparam int LIST_LEN    = 2 * MAX_PATTERN;
  localparam int LIST_CNT_W  = $clog2(LIST_LEN + 1);
  localparam int LIST_IDX_W  = $clog2(LIST_LEN);
  localparam int EMIT_DEPTH  = LIST_LEN + 1;
  localparam int EMIT_CNT_W  = $clog2(EMIT_DEPTH + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 64;

  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [LEN_W-1:0]      len_t;
  typedef logic [WIN_IDX_W-1:0]  widx_t;
  typedef logic [LIST_CNT_W-1:0] lcnt_t;
  typedef logic [LIST_IDX_W-1:0] lidx_t;
  typedef logic [EMIT_CNT_W-1:0] ecnt_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;

  // Register indexes of the configuration port
  localparam cfg_idx_t CFG_MODE      = cfg_idx_t'(0);
  localparam cfg_idx_t CFG_PATTERN   = cfg_idx_t'(1);
  localparam cfg_idx_t CFG_PAT_LEN   = cfg_idx_t'(2);
  localparam cfg_idx_t CFG_REPL      = cfg_idx_t'(3);
  localparam cfg_idx_t CFG_REPL_LEN  = cfg_idx_t'(4);

  typedef enum logic [1:0] {
    MODE_DELETE  = 2'd0,
    MODE_DUP     = 2'd1,
    MODE_REPLACE = 2'd2,
    MODE_KEEP    = 2'd3
  } mode_t;

  typedef struct packed {
    byte_t text_byte;
    logic  text_last;
  } in_data_t;

  typedef struct packed {
    byte_t out_byte;
    logic  out_valid;
    logic  out_last;
  } out_data_t;

  // Per-cell control of the output chain
  typedef struct packed {
    logic load;
    logic shift;
  } emit_ctl_t;

  // Map a length register onto 1..MAX_PATTERN
  function automatic len_t clamp_len(input len_t v);
    len_t r;
    if (v == '0) begin
      r = len_t'(1);
    end else if (v > len_t'(MAX_PATTERN)) begin
      r = len_t'(MAX_PATTERN);
    end else begin
      r = v;
    end
    return r;
  endfunction

  // Pick byte idx of a packed byte string, first byte in the low bits
  function automatic byte_t packed_byte(input logic [PACK_W-1:0] word, input widx_t idx);
    return word[idx*BYTE_W +: BYTE_W];
  endfunction

endpackage

// File: rtl/stream_find_and_replace_core.sv
// Top level of the stream find-and-replace core: config registers, window row, output chain.
// Depends on sfr_pkg, sfr_win_cell, sfr_emit_cell and stream_find_and_replace_core_defines.svh.
//
// Usage:
//   in_*  : one text byte per transaction, text_last on the final byte of a string.
//   out_* : one result item per transaction; out_valid in the payload is 0 only for a
//           bare end marker, out_last marks the final item of the string.
//   cfg_* : register writes (mode, pattern, pattern length, replacement, replacement length),
//           always ready and taken: the user must write only while no string is in progress.
// Results: the results of an item are registered into the output chain when it is accepted
//   and appear on out_* in the next cycle, behind a result that is still queued.
// Throughput: one item per cycle while each item yields at most one result and the receiver
//   does not stall. An item that yields several results holds the output until they drain;
//   the 17-entry output chain drains one item per cycle while out_ready is high; a new input
//   is taken whenever at most one result is queued, so a single waiting result never blocks it.
// Reset: window empty, output chain empty, registers at mode 0, lengths 1, strings 0.
//   No clearing pass is needed.
// Receiver stall: the queued result holds on out_data; once an item that yields results
//   is taken behind it, in_ready drops until at most one result is left in the chain.
`include "stream_find_and_replace_core_defines.svh"

module stream_find_and_replace_core (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  sfr_pkg::in_data_t          in_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output sfr_pkg::out_data_t         out_data,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  sfr_pkg::cfg_idx_t          cfg_index,
  input  logic [sfr_pkg::CFG_DATA_W-1:0] cfg_data
);

  // Configuration registers
  sfr_pkg::mode_t                 mode_r;
  logic [sfr_pkg::PACK_W-1:0]     pat_r;
  logic [sfr_pkg::PACK_W-1:0]     rep_r;
  sfr_pkg::len_t                  plen_r;
  sfr_pkg::len_t                  rlen_r;

  // Window and output chain state
  sfr_pkg::len_t                  fill_r;
  sfr_pkg::len_t                  fill_nxt;
  sfr_pkg::ecnt_t                 emit_cnt_r;
  sfr_pkg::ecnt_t                 emit_cnt_nxt;

  sfr_pkg::byte_t                 win_view [sfr_pkg::MAX_PATTERN];
  logic                           win_eq   [sfr_pkg::MAX_PATTERN];
  sfr_pkg::byte_t                 win_nxt  [sfr_pkg::MAX_PATTERN];

  sfr_pkg::len_t                  plen;
  sfr_pkg::len_t                  rlen;
  sfr_pkg::len_t                  fill_new;
  sfr_pkg::len_t                  drop;
  sfr_pkg::len_t                  rem_fill;
  logic                           decide;
  logic                           all_eq;
  logic                           hit;
  logic                           marker;
  logic                           in_fire;
  logic                           out_fire;
  logic                           base;
  sfr_pkg::lcnt_t                 head_cnt;
  sfr_pkg::lcnt_t                 tail_cnt;
  sfr_pkg::lcnt_t                 list_cnt;
  sfr_pkg::lcnt_t                 n_eff;
  sfr_pkg::lcnt_t                 kk;
  sfr_pkg::lcnt_t                 t;
  sfr_pkg::lcnt_t                 src;
  sfr_pkg::byte_t                 b;
  sfr_pkg::ecnt_t                 rel;

  sfr_pkg::out_data_t             list_item [sfr_pkg::LIST_LEN];
  sfr_pkg::out_data_t             emit_q    [sfr_pkg::EMIT_DEPTH];
  sfr_pkg::out_data_t             emit_ld   [sfr_pkg::EMIT_DEPTH];
  sfr_pkg::out_data_t             emit_next [sfr_pkg::EMIT_DEPTH];
  sfr_pkg::emit_ctl_t             emit_ctl  [sfr_pkg::EMIT_DEPTH];

  // Write configuration registers
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= sfr_pkg::MODE_DELETE;
      pat_r  <= '0;
      plen_r <= sfr_pkg::len_t'(1);
      rep_r  <= '0;
      rlen_r <= sfr_pkg::len_t'(1);
    end else if (cfg_valid) begin
      case (cfg_index)
        sfr_pkg::CFG_MODE:     mode_r <= sfr_pkg::mode_t'(cfg_data[1:0]);
        sfr_pkg::CFG_PATTERN:  pat_r  <= cfg_data[sfr_pkg::PACK_W-1:0];
        sfr_pkg::CFG_PAT_LEN:  plen_r <= cfg_data[sfr_pkg::LEN_W-1:0];
        sfr_pkg::CFG_REPL:     rep_r  <= cfg_data[sfr_pkg::PACK_W-1:0];
        sfr_pkg::CFG_REPL_LEN: rlen_r <= cfg_data[sfr_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  // Handshake
  assign in_ready  = (emit_cnt_r <= sfr_pkg::ecnt_t'(1));
  assign in_fire   = in_valid && in_ready;
  assign out_valid = (emit_cnt_r != '0);
  assign out_fire  = out_valid && out_ready;
  assign out_data  = emit_q[0];

  // Window row: the cell at the fill position sees the new byte
  for (genvar gi = 0; gi < sfr_pkg::MAX_PATTERN; gi++) begin : g_win
    sfr_win_cell u_win_cell (
      .clk      (clk),
      .en       (in_fire),
      .tail     (fill_r == sfr_pkg::len_t'(gi)),
      .in_byte  (in_data.text_byte),
      .pat_byte (pat_r[gi*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W]),
      .nxt_byte (win_nxt[gi]),
      .cur_byte (win_view[gi]),
      .byte_eq  (win_eq[gi])
    );
  end

  // Decide on the oldest bytes and build the result list
  always_comb begin
    plen     = sfr_pkg::clamp_len(plen_r);
    rlen     = sfr_pkg::clamp_len(rlen_r);
    fill_new = fill_r + sfr_pkg::len_t'(1);
    decide   = (fill_new >= plen);

    all_eq = 1'b1;
    for (int i = 0; i < sfr_pkg::MAX_PATTERN; i++) begin
      if ((sfr_pkg::len_t'(i) < plen) && !win_eq[i]) begin
        all_eq = 1'b0;
      end
    end
    hit = decide && all_eq;

    // Drop the whole match on a hit, else the oldest byte once the window is full enough
    if (hit) begin
      drop = plen;
    end else if (decide) begin
      drop = sfr_pkg::len_t'(1);
    end else begin
      drop = '0;
    end
    rem_fill = fill_new - drop;

    // Count the substitution bytes (or the released oldest byte on a miss) and the flushed remainder
    head_cnt = '0;
    if (hit) begin
      case (mode_r)
        sfr_pkg::MODE_DUP:     head_cnt = sfr_pkg::lcnt_t'({plen, 1'b0});
        sfr_pkg::MODE_REPLACE: head_cnt = sfr_pkg::lcnt_t'(rlen);
        sfr_pkg::MODE_KEEP:    head_cnt = sfr_pkg::lcnt_t'(plen);
        default:               head_cnt = '0;
      endcase
    end else if (decide) begin
      head_cnt = sfr_pkg::lcnt_t'(1);
    end
    tail_cnt = in_data.text_last ? sfr_pkg::lcnt_t'(rem_fill) : '0;
    list_cnt = head_cnt + tail_cnt;
    marker   = in_data.text_last && (list_cnt == '0);
    n_eff    = marker ? sfr_pkg::lcnt_t'(1) : list_cnt;

    // Substitution bytes first, then the flushed window remainder
    for (int k = 0; k < sfr_pkg::LIST_LEN; k++) begin
      kk = sfr_pkg::lcnt_t'(k);
      t  = '0;
      if (kk < head_cnt) begin
        if (!hit) begin
          b = win_view[0];
        end else begin
          case (mode_r)
            sfr_pkg::MODE_DUP: begin
              if (kk < sfr_pkg::lcnt_t'(plen)) begin
                b = sfr_pkg::packed_byte(pat_r, sfr_pkg::widx_t'(kk));
              end else begin
                b = sfr_pkg::packed_byte(pat_r,
                      sfr_pkg::widx_t'(kk - sfr_pkg::lcnt_t'(plen)));
              end
            end
            sfr_pkg::MODE_REPLACE: b = sfr_pkg::packed_byte(rep_r, sfr_pkg::widx_t'(kk));
            default:               b = sfr_pkg::packed_byte(pat_r, sfr_pkg::widx_t'(kk));
          endcase
        end
      end else begin
        t = kk - head_cnt + sfr_pkg::lcnt_t'(drop);
        b = (t < sfr_pkg::lcnt_t'(sfr_pkg::MAX_PATTERN)) ? win_view[sfr_pkg::widx_t'(t)] : '0;
      end
      list_item[k].out_byte  = b;
      list_item[k].out_valid = 1'b1;
      list_item[k].out_last  = in_data.text_last && (kk == list_cnt - sfr_pkg::lcnt_t'(1));
    end

    // Bare end marker when the last byte yields nothing
    if (marker) begin
      list_item[0].out_byte  = '0;
      list_item[0].out_valid = 1'b0;
      list_item[0].out_last  = 1'b1;
    end

    // Shift the window by the dropped count
    for (int i = 0; i < sfr_pkg::MAX_PATTERN; i++) begin
      src = sfr_pkg::lcnt_t'(i) + sfr_pkg::lcnt_t'(drop);
      win_nxt[i] = (src < sfr_pkg::lcnt_t'(sfr_pkg::MAX_PATTERN)) ?
                   win_view[sfr_pkg::widx_t'(src)] : '0;
    end

    fill_nxt = in_fire ? (in_data.text_last ? '0 : rem_fill) : fill_r;
  end

  // Output chain control: append behind a result that stays queued
  always_comb begin
    base = (emit_cnt_r == sfr_pkg::ecnt_t'(1)) && !out_fire;
    for (int j = 0; j < sfr_pkg::EMIT_DEPTH; j++) begin
      rel = sfr_pkg::ecnt_t'(j) - sfr_pkg::ecnt_t'(base);
      emit_ctl[j].load  = in_fire && (sfr_pkg::ecnt_t'(j) >= sfr_pkg::ecnt_t'(base)) &&
                          (rel < sfr_pkg::ecnt_t'(n_eff));
      emit_ctl[j].shift = out_fire;
      emit_ld[j] = (rel < sfr_pkg::ecnt_t'(sfr_pkg::LIST_LEN)) ?
                   list_item[sfr_pkg::lidx_t'(rel)] : '0;
    end
    if (in_fire) begin
      emit_cnt_nxt = sfr_pkg::ecnt_t'(base) + sfr_pkg::ecnt_t'(n_eff);
    end else begin
      emit_cnt_nxt = emit_cnt_r - sfr_pkg::ecnt_t'(out_fire);
    end
  end

  // Output chain: cell 0 drives the result channel
  for (genvar gj = 0; gj < sfr_pkg::EMIT_DEPTH; gj++) begin : g_emit
    if (gj < sfr_pkg::EMIT_DEPTH - 1) begin : g_mid
      assign emit_next[gj] = emit_q[gj+1];
    end else begin : g_end
      assign emit_next[gj] = '0;
    end
    sfr_emit_cell u_emit_cell (
      .clk       (clk),
      .ctl       (emit_ctl[gj]),
      .ld_item   (emit_ld[gj]),
      .next_item (emit_next[gj]),
      .item      (emit_q[gj])
    );
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r     <= '0;
      emit_cnt_r <= '0;
    end else begin
      fill_r     <= fill_nxt;
      emit_cnt_r <= emit_cnt_nxt;
    end
  end

  // Checks
  `SFR_ASSERT(a_emit_cnt_bound, emit_cnt_r <= sfr_pkg::ecnt_t'(sfr_pkg::EMIT_DEPTH))
  `SFR_ASSERT(a_window_not_full, fill_r < sfr_pkg::len_t'(sfr_pkg::MAX_PATTERN))
  `SFR_ASSERT_STEP(a_last_empties_window, in_fire && in_data.text_last, fill_r == '0)
  `SFR_ASSERT_STEP(a_last_gives_result, in_fire && in_data.text_last, emit_cnt_r != '0)

endmodule

// File: rtl/sfr_win_cell.sv
// One cell of the match window: holds a text byte and compares it with its pattern byte.
// Depends on sfr_pkg.
module sfr_win_cell (
  input  logic           clk,
  input  logic           en,
  input  logic           tail,
  input  sfr_pkg::byte_t in_byte,
  input  sfr_pkg::byte_t pat_byte,
  input  sfr_pkg::byte_t nxt_byte,
  output sfr_pkg::byte_t cur_byte,
  output logic           byte_eq
);

  sfr_pkg::byte_t byte_r;
  sfr_pkg::byte_t byte_nxt;

  // The tail cell sees the incoming byte in the cycle it arrives
  assign cur_byte = tail ? in_byte : byte_r;
  assign byte_eq  = (cur_byte == pat_byte);

  // Take the byte of the window shifted by the dropped count on each accepted transaction
  assign byte_nxt = en ? nxt_byte : byte_r;

  always_ff @(posedge clk) begin
    byte_r <= byte_nxt;
  end

endmodule

// File: rtl/sfr_emit_cell.sv
// One cell of the output chain: loads a result item or takes its neighbor's item.
// Depends on sfr_pkg.
module sfr_emit_cell (
  input  logic                clk,
  input  sfr_pkg::emit_ctl_t  ctl,
  input  sfr_pkg::out_data_t  ld_item,
  input  sfr_pkg::out_data_t  next_item,
  output sfr_pkg::out_data_t  item
);

  sfr_pkg::out_data_t item_r;
  sfr_pkg::out_data_t item_nxt;

  // Load wins over shift; otherwise hold
  always_comb begin
    if (ctl.load) begin
      item_nxt = ld_item;
    end else if (ctl.shift) begin
      item_nxt = next_item;
    end else begin
      item_nxt = item_r;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign item = item_r;

endmodule

// File: tb/sv/tb_stream_find_and_replace_core.sv
`timescale 1ns / 1ps
// Self-checking testbench for stream_find_and_replace_core: a directed table, then random
// strings under several handshake idle profiles. Depends on sfr_pkg and the core RTL.

module tb_stream_find_and_replace_core;
  import sfr_pkg::*;

  localparam int ITEMS_PER_PHASE = 36;
  localparam int PHASES          = 10;
  localparam int SETTLE_CYCLES   = 24;
  localparam int HOLD_CYCLES     = 300;
  localparam int DIRECTED_ROWS   = 48;
  localparam cfg_idx_t  CFG_UNUSED = cfg_idx_t'(5);
  localparam in_data_t  NO_TEXT    = '0;
  localparam out_data_t NO_RES     = '0;

  typedef enum bit {ROW_WRITE, ROW_TEXT} row_kind_t;

  typedef struct {
    row_kind_t   kind;
    cfg_idx_t    reg_idx;
    logic [63:0] reg_val;
    in_data_t    text;
    bit          typed;
    out_data_t   typed_res;
  } directed_row_t;

  logic                  clk;
  logic                  rst_n        = 1'b0;
  logic                  in_valid     = 1'b0;
  logic                  in_ready;
  in_data_t              in_data      = '0;
  logic                  out_valid;
  logic                  out_ready    = 1'b0;
  out_data_t             out_data;
  logic                  cfg_valid    = 1'b0;
  logic                  cfg_ready;
  cfg_idx_t              cfg_index    = CFG_MODE;
  logic [CFG_DATA_W-1:0] cfg_data     = '0;

  // Typed expectation that travels alongside the input transaction
  bit        in_typed     = 1'b0;
  out_data_t in_typed_res = '0;

  // Handshake profile and bookkeeping
  int send_idle_pct  = 0;
  int stall_pct      = 0;
  bit pressure_req   = 1'b0;
  int hold_left      = 0;
  bit hold_done      = 1'b0;
  int sent_items     = 0;
  int mismatch_count = 0;

  // Current phase pattern, used to build matching text
  logic [63:0] phase_pat  = '0;
  int          phase_plen = 1;
  byte_t       alph [2];

  // Predictor state: register copy and the undecided window
  mode_t       rule_mode    = MODE_DELETE;
  logic [63:0] pat_chars    = '0;
  len_t        pat_len_reg  = len_t'(1);
  logic [63:0] repl_chars   = '0;
  len_t        repl_len_reg = len_t'(1);
  byte_t       win_bytes [MAX_PATTERN];
  int          win_fill     = 0;
  out_data_t   step_out [$];
  out_data_t   expected_text_q [$];

  directed_row_t directed_rows [DIRECTED_ROWS];

  stream_find_and_replace_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Map a length register onto 1..MAX_PATTERN
  function automatic int eff_len(input len_t v);
    return (v == len_t'(0)) ? 1 : (v > len_t'(MAX_PATTERN)) ? MAX_PATTERN : int'(v);
  endfunction

  function automatic void emit_byte(input byte_t b);
    step_out.push_back(out_data_t'{out_byte: b, out_valid: 1'b1, out_last: 1'b0});
  endfunction

  // Drop the k oldest window bytes
  function automatic void drop_window(input int k);
    int i;
    if (k >= win_fill) begin
      win_fill = 0;
    end else begin
      for (i = 0; i < win_fill - k; i++) win_bytes[i] = win_bytes[i + k];
      win_fill -= k;
    end
  endfunction

  // Advance the window by one text byte and collect the bytes it releases
  function automatic void rewrite_text_byte(input in_data_t d);
    int        plen;
    int        rlen;
    int        i;
    bit        hit;
    out_data_t tail;
    plen = eff_len(pat_len_reg);
    rlen = eff_len(repl_len_reg);
    step_out.delete();
    // a full window pushes out its oldest byte before the new one lands
    if (win_fill >= MAX_PATTERN) begin
      emit_byte(win_bytes[0]);
      drop_window(1);
    end
    win_bytes[win_fill] = d.text_byte;
    win_fill++;
    if (win_fill >= plen) begin
      hit = 1'b1;
      for (i = 0; i < plen; i++) begin
        if (win_bytes[i] != pat_chars[8*i +: 8]) hit = 1'b0;
      end
      if (hit) begin
        case (rule_mode)
          MODE_DUP:     for (i = 0; i < 2 * plen; i++) emit_byte(pat_chars[8*(i % plen) +: 8]);
          MODE_REPLACE: for (i = 0; i < rlen; i++) emit_byte(repl_chars[8*i +: 8]);
          MODE_KEEP:    for (i = 0; i < plen; i++) emit_byte(win_bytes[i]);
          default: ;
        endcase
        drop_window(plen);
      end else begin
        emit_byte(win_bytes[0]);
        drop_window(1);
      end
    end
    // flush the rest unscanned and tag the end of the string
    if (d.text_last) begin
      for (i = 0; i < win_fill; i++) emit_byte(win_bytes[i]);
      win_fill = 0;
      if (step_out.size() == 0) begin
        step_out.push_back(out_data_t'{out_byte: 8'h00, out_valid: 1'b0, out_last: 1'b1});
      end else begin
        tail = step_out.pop_back();
        tail.out_last = 1'b1;
        step_out.push_back(tail);
      end
    end
  endfunction

  function automatic len_t random_len();
    int v;
    v = $urandom_range(7);
    if ($urandom_range(99) < 85) return len_t'($urandom_range(1, MAX_PATTERN));
    return (v == 0) ? len_t'(0) : len_t'(v + 8);
  endfunction

  // Check results against the oldest expectation, then record new ones
  always @(posedge clk) begin : scoreboard
    out_data_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_text_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual byte %02h valid %0b last %0b",
                 $time, out_data.out_byte, out_data.out_valid, out_data.out_last);
        mismatch_count++;
      end else begin
        want = expected_text_q.pop_front();
        if (out_data.out_byte !== want.out_byte) begin
          $display("%0t: out_byte mismatch, expected %02h actual %02h",
                   $time, want.out_byte, out_data.out_byte);
          mismatch_count++;
        end
        if (out_data.out_valid !== want.out_valid) begin
          $display("%0t: out_valid mismatch, expected %0b actual %0b",
                   $time, want.out_valid, out_data.out_valid);
          mismatch_count++;
        end
        if (out_data.out_last !== want.out_last) begin
          $display("%0t: out_last mismatch, expected %0b actual %0b",
                   $time, want.out_last, out_data.out_last);
          mismatch_count++;
        end
      end
    end
    if (rst_n && in_valid && in_ready) begin
      rewrite_text_byte(in_data);
      if (in_typed) begin
        expected_text_q.push_back(in_typed_res);
      end else begin
        foreach (step_out[k]) expected_text_q.push_back(step_out[k]);
      end
    end
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_MODE:     rule_mode    = mode_t'(cfg_data[1:0]);
        CFG_PATTERN:  pat_chars    = cfg_data;
        CFG_PAT_LEN:  pat_len_reg  = cfg_data[3:0];
        CFG_REPL:     repl_chars   = cfg_data;
        CFG_REPL_LEN: repl_len_reg = cfg_data[3:0];
        default: ;
      endcase
    end
  end

  // Receiver: random stalls, plus one long hold-off while the sender keeps going
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (pressure_req && !hold_done) begin
      out_ready <= 1'b0;
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // Offer one text byte after a random idle gap; hold it until accepted
  task automatic send_item(input in_data_t d, input bit typed, input out_data_t typed_res);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_data      <= d;
    in_typed     <= typed;
    in_typed_res <= typed_res;
    do @(posedge clk); while (!in_ready);
    sent_items++;
  endtask

  // Issue one register write; the caller lowers cfg_valid after the last one
  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Hold input, wait for every expected result, then let the block settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_text_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Build one string mostly from whole and partial pattern copies, with noise
  task automatic send_string(input int pieces);
    byte_t text [$];
    int    r;
    int    cut;
    int    k;
    repeat (pieces) begin
      r = $urandom_range(99);
      if (r < 45) cut = phase_plen;
      else if (r < 65) cut = $urandom_range(phase_plen - 1);
      else cut = 0;
      for (k = 0; k < cut; k++) text.push_back(phase_pat[8*k +: 8]);
      if (r >= 85) text.push_back(byte_t'($urandom_range(255)));
      else if (r >= 65) text.push_back(alph[$urandom_range(1)]);
    end
    if (text.size() == 0) text.push_back(byte_t'($urandom_range(255)));
    for (k = 0; k < text.size(); k++) begin
      send_item(in_data_t'{text_byte: text[k], text_last: (k == text.size() - 1)},
                1'b0, NO_RES);
    end
  endtask

  initial begin
    int          p;
    int          k;
    int          goal;
    logic [1:0]  mode_v;
    len_t        plen_v;
    len_t        rlen_v;
    logic [63:0] upper;
    logic [63:0] repl_v;
    bit          cfg_open;
    bit          text_pending;

    directed_rows = '{
      // reset state: delete a one-byte zero pattern
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'h00, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1}},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'hFF, 1'b1}, 1'b1, '{8'hFF, 1'b1, 1'b1}},
      // replace "ab" with "XYZ", overlapping start
      '{ROW_WRITE, CFG_MODE,     64'(MODE_REPLACE), NO_TEXT, 1'b0, NO_RES},
      '{ROW_WRITE, CFG_PATTERN,  64'h6261,          NO_TEXT, 1'b0, NO_RES},
      '{ROW_WRITE, CFG_PAT_LEN,  64'd2,             NO_TEXT, 1'b0, NO_RES},
      '{ROW_WRITE, CFG_REPL,     64'h5A5958,        NO_TEXT, 1'b0, NO_RES},
      '{ROW_WRITE, CFG_REPL_LEN, 64'd3,             NO_TEXT, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'h61, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'h61, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'h62, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'h63, 1'b1}, 1'b0, NO_RES},
      // duplicate a full-length pattern: sixteen results from one byte
      '{ROW_WRITE, CFG_MODE,     64'(MODE_DUP),     NO_TEXT, 1'b0, NO_RES},
      '{ROW_WRITE, CFG_PATTERN,  '1,                NO_TEXT, 1'b0, NO_RES},
      '{ROW_WRITE, CFG_PAT_LEN,  64'd8,             NO_TEXT, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'hFF, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'hFF, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'hFF, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'hFF, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'hFF, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'hFF, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'hFF, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'hFF, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'h00, 1'b1}, 1'b0, NO_RES},
      // unused mode keeps matches; zero length acts as one
      '{ROW_WRITE, CFG_MODE,     64'(MODE_KEEP),    NO_TEXT, 1'b0, NO_RES},
      '{ROW_WRITE, CFG_PATTERN,  64'd0,             NO_TEXT, 1'b0, NO_RES},
      '{ROW_WRITE, CFG_PAT_LEN,  64'd0,             NO_TEXT, 1'b0, NO_RES},
      '{ROW_WRITE, CFG_REPL_LEN, 64'd15,            NO_TEXT, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'h00, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'h00, 1'b1}, 1'b0, NO_RES},
      // upper data bits ignored, over-range pattern length, zero replacement length
      '{ROW_WRITE, CFG_MODE,     64'hFFFF_FFFF_FFFF_FFFE, NO_TEXT, 1'b0, NO_RES},
      '{ROW_WRITE, CFG_PATTERN,  64'h7171_7171_7171_7171, NO_TEXT, 1'b0, NO_RES},
      '{ROW_WRITE, CFG_PAT_LEN,  '1,                      NO_TEXT, 1'b0, NO_RES},
      '{ROW_WRITE, CFG_REPL,     64'h0123_4567_89AB_CDA5, NO_TEXT, 1'b0, NO_RES},
      '{ROW_WRITE, CFG_REPL_LEN, 64'hF0,                  NO_TEXT, 1'b0, NO_RES},
      '{ROW_WRITE, CFG_UNUSED,   64'h5555_5555_5555_5555, NO_TEXT, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'h71, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'h71, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'h71, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'h71, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'h71, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'h71, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'h71, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'h71, 1'b1}, 1'b0, NO_RES},
      // a match swallows the whole string: bare end marker
      '{ROW_WRITE, CFG_MODE,     64'(MODE_DELETE),  NO_TEXT, 1'b0, NO_RES},
      '{ROW_WRITE, CFG_PATTERN,  64'h6261,          NO_TEXT, 1'b0, NO_RES},
      '{ROW_WRITE, CFG_PAT_LEN,  64'd2,             NO_TEXT, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'h61, 1'b0}, 1'b0, NO_RES},
      '{ROW_TEXT,  CFG_MODE,     64'd0, '{8'h62, 1'b1}, 1'b1, '{8'h00, 1'b0, 1'b1}}
    };

    cfg_open     = 1'b0;
    text_pending = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table; drain before each group of register writes
    for (k = 0; k < DIRECTED_ROWS; k++) begin
      if (directed_rows[k].kind == ROW_WRITE) begin
        if (text_pending) begin
          wait_drained();
          text_pending = 1'b0;
        end
        write_reg(directed_rows[k].reg_idx, directed_rows[k].reg_val);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_item(directed_rows[k].text, directed_rows[k].typed, directed_rows[k].typed_res);
        text_pending = 1'b1;
      end
    end

    // Random phases: new settings, new idle profile, then strings
    for (p = 0; p < PHASES; p++) begin
      wait_drained();
      mode_v = (p < 4) ? 2'(p) : 2'($urandom_range(3));
      plen_v = (p == 0) ? len_t'(1) : (p == 1) ? len_t'(MAX_PATTERN) : random_len();
      rlen_v = (p == 1) ? len_t'(MAX_PATTERN) : (p == 2) ? len_t'(1) : random_len();
      alph[0]   = byte_t'($urandom_range(255));
      alph[1]   = byte_t'($urandom_range(255));
      phase_pat = {$urandom, $urandom};
      for (k = 0; k < MAX_PATTERN; k++) begin
        if ($urandom_range(99) < 60) phase_pat[8*k +: 8] = alph[$urandom_range(1)];
      end
      phase_plen = eff_len(plen_v);
      repl_v     = {$urandom, $urandom};
      upper      = $urandom_range(1) ? {$urandom, $urandom} : '0;

      write_reg(CFG_MODE,     {upper[63:2], mode_v});
      write_reg(CFG_PATTERN,  phase_pat);
      write_reg(CFG_PAT_LEN,  {upper[63:4], plen_v});
      write_reg(CFG_REPL,     repl_v);
      write_reg(CFG_REPL_LEN, {upper[63:4], rlen_v});
      cfg_valid <= 1'b0;

      case (p % 5)
        0:       begin send_idle_pct = 0;  stall_pct <= 0;  end
        1:       begin send_idle_pct = 78; stall_pct <= 0;  end
        2:       begin send_idle_pct = 0;  stall_pct <= 78; end
        3:       begin send_idle_pct = 15; stall_pct <= 15; end
        default: begin send_idle_pct = 0;  stall_pct <= 0;  end
      endcase
      pressure_req <= (p == 4);

      goal = sent_items + ITEMS_PER_PHASE;
      while (sent_items < goal) send_string($urandom_range(1, 6));
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("stream_find_and_replace_core test passed");
    end else begin
      $display("stream_find_and_replace_core test failed");
    end
    $finish;
  end

  // Bound the run
  initial begin
    #2_000_000;
    $display("stream_find_and_replace_core test failed");
    $finish;
  end

endmodule
